>>> sv/lbfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbfp_pkg;

  // fixed widths of the stream fields
  localparam int unsigned FieldValueW = 64;
  localparam int unsigned FieldWidthW = 7;
  localparam int unsigned CapW        = 16;
  localparam int unsigned PosW        = 19;
  localparam int unsigned ByteCntW    = 4;
  localparam int unsigned MaxFieldBits = 64;

  // reset value of the capacity register
  localparam logic [CapW-1:0] CapResetVal = 16'hFFFF;

  // default depth of the queue between front and back
  localparam int unsigned DefQueueDepth = 2;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadArg   = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef enum logic {
    ActWrite = 1'b0,
    ActAlign = 1'b1
  } action_e;

  // one classified item handed from front to back
  typedef struct packed {
    logic [FieldValueW-1:0] data;     // completed bytes, byte 0 lowest
    logic [ByteCntW-1:0]    nbytes;   // number of completed bytes, 0 to 8
    status_e                status;   // status after this item
    logic [PosW-1:0]        bits;     // bit position after this item
  } job_t;

endpackage

`default_nettype wire

>>> sv/lbfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lbfp_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // capacity register write
  input  wire logic                            cfg_we_i,
  input  wire logic [lbfp_pkg::CapW-1:0]       cfg_data_i,
  // accepted input transaction
  input  wire logic                            item_accept_i,
  input  wire logic                            item_action_i,
  input  wire logic [lbfp_pkg::FieldValueW-1:0] item_value_i,
  input  wire logic [lbfp_pkg::FieldWidthW-1:0] item_width_i,
  // classified job toward the queue
  output lbfp_pkg::job_t                       job_o
);

  logic [lbfp_pkg::CapW-1:0]   cap_q;
  logic [lbfp_pkg::PosW-1:0]   pos_q, pos_d;
  logic [7:0]                  partial_q, partial_d;
  lbfp_pkg::status_e           status_q, status_d;

  logic [lbfp_pkg::PosW-1:0]   cap_bits;
  logic [lbfp_pkg::PosW-1:0]   room;
  logic [2:0]                  off;
  logic [lbfp_pkg::FieldWidthW-1:0] n_req;
  logic [lbfp_pkg::FieldWidthW-1:0] n_take;
  logic [lbfp_pkg::FieldValueW-1:0] val_src;
  logic [lbfp_pkg::FieldValueW-1:0] val_mask;
  logic [lbfp_pkg::FieldValueW+7:0] wide;
  logic [lbfp_pkg::FieldValueW+7:0] wide_sh;
  logic [lbfp_pkg::FieldWidthW-1:0] total;
  logic [lbfp_pkg::ByteCntW-1:0]    nbytes;
  logic                        bad_arg;
  logic                        overflow;

  // room left in the destination, in bits
  assign cap_bits = {cap_q, 3'b000};
  assign room     = (pos_q >= cap_bits) ? '0 : (cap_bits - pos_q);
  assign off      = pos_q[2:0];

  // classify the item: how many bits it asks for and which ones
  always_comb begin
    n_req   = '0;
    val_src = '0;
    bad_arg = 1'b0;
    if (status_q == lbfp_pkg::StatusOk) begin
      if (lbfp_pkg::action_e'(item_action_i) == lbfp_pkg::ActAlign) begin
        n_req = (off != 3'd0) ? (lbfp_pkg::FieldWidthW'(8) - {4'b0000, off}) : '0;
      end else if (item_width_i > lbfp_pkg::FieldWidthW'(lbfp_pkg::MaxFieldBits)) begin
        bad_arg = 1'b1;
      end else begin
        n_req   = item_width_i;
        val_src = item_value_i;
      end
    end
  end

  // clip to the room left, the rest of the field is dropped
  assign overflow = {{(lbfp_pkg::PosW-lbfp_pkg::FieldWidthW){1'b0}}, n_req} > room;
  assign n_take   = overflow ? room[lbfp_pkg::FieldWidthW-1:0] : n_req;

  always_comb begin
    if (n_take >= lbfp_pkg::FieldWidthW'(lbfp_pkg::MaxFieldBits)) begin
      val_mask = '1;
    end else begin
      val_mask = (lbfp_pkg::FieldValueW'(1) << n_take) - lbfp_pkg::FieldValueW'(1);
    end
  end

  // merge new bits above the pending partial byte
  assign wide    = ({8'h00, val_src & val_mask} << off) |
                   {{lbfp_pkg::FieldValueW{1'b0}}, partial_q};
  assign total   = {4'b0000, off} + n_take;
  assign nbytes  = total[lbfp_pkg::FieldWidthW-1:3];
  assign wide_sh = wide >> {nbytes, 3'b000};

  // next state
  always_comb begin
    pos_d     = pos_q;
    partial_d = partial_q;
    status_d  = status_q;
    if (item_accept_i) begin
      pos_d     = pos_q + {{(lbfp_pkg::PosW-lbfp_pkg::FieldWidthW){1'b0}}, n_take};
      partial_d = wide_sh[7:0];
      if (bad_arg) begin
        status_d = lbfp_pkg::StatusBadArg;
      end else if (overflow) begin
        status_d = lbfp_pkg::StatusOverflow;
      end
    end
  end

  // job contents reflect the state after the item
  always_comb begin
    job_o.data   = wide[lbfp_pkg::FieldValueW-1:0];
    job_o.nbytes = nbytes;
    job_o.bits   = pos_d;
    job_o.status = status_d;
    if (bad_arg) begin
      job_o.status = lbfp_pkg::StatusBadArg;
    end else if (overflow) begin
      job_o.status = lbfp_pkg::StatusOverflow;
    end
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= lbfp_pkg::CapResetVal;
      pos_q     <= '0;
      partial_q <= '0;
      status_q  <= lbfp_pkg::StatusOk;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      pos_q     <= pos_d;
      partial_q <= partial_d;
      status_q  <= status_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/lbfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lbfp_queue #(
  parameter int unsigned Depth = lbfp_pkg::DefQueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lbfp_pkg::job_t push_job_i,
  input  wire logic           pop_i,
  output lbfp_pkg::job_t      head_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  lbfp_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/lbfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lbfp_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // queue head
  input  wire lbfp_pkg::job_t            head_i,
  input  wire logic                      empty_i,
  output logic                           pop_o,
  // result stream
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           out_byte_valid_o,
  output logic                           out_last_o,
  output lbfp_pkg::status_e              out_status_o,
  output logic [lbfp_pkg::PosW-1:0]      out_bits_o
);

  logic [2:0]                       idx_q, idx_d;
  logic                             valid_q, valid_d;
  logic [7:0]                       byte_q;
  logic                             byte_valid_q;
  logic                             last_q;
  lbfp_pkg::status_e                status_q;
  logic [lbfp_pkg::PosW-1:0]        bits_q;

  logic                             emit;
  logic                             no_bytes;
  logic                             is_last;
  logic [lbfp_pkg::FieldValueW-1:0] data_sh;

  // a result leaves the head when the output slot is free
  assign emit     = !empty_i && (!valid_q || out_ready_i);
  assign no_bytes = (head_i.nbytes == '0);
  assign is_last  = no_bytes ||
                    ({1'b0, idx_q} == (head_i.nbytes - lbfp_pkg::ByteCntW'(1)));
  assign data_sh  = head_i.data >> {idx_q, 3'b000};
  assign pop_o    = emit && is_last;

  // byte counter and output slot occupancy
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (emit) begin
      valid_d = 1'b1;
      idx_d   = is_last ? '0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q       <= no_bytes ? 8'h00 : data_sh[7:0];
      byte_valid_q <= !no_bytes;
      last_q       <= is_last;
      status_q     <= head_i.status;
      bits_q       <= head_i.bits;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = byte_q;
  assign out_byte_valid_o = byte_valid_q;
  assign out_last_o       = last_q;
  assign out_status_o     = status_q;
  assign out_bits_o       = bits_q;

endmodule

`default_nettype wire

>>> sv/lsb_first_bit_field_packer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// LSB-first bit field packer: each input transaction writes a field of 0 to 64
// bits (or pads to the next byte boundary with zeros) into a byte stream, bit 0
// of each byte filled first, and produces one result per completed byte, or a
// single result with byte_valid low when no byte completes; every result of a
// transaction carries the status and bit position as they stand after it, and
// tlast marks its final result. Bad widths (above 64) and writes past
// capacity_bytes set a sticky status, after which inputs are ignored. The front
// classifies and updates the stream state in the cycle a transaction is
// accepted, so an input can be taken every cycle while the queue has room; the
// back drains the queue at one result per cycle while the receiver is ready; a
// transaction yields max(1, completed bytes) results, 1 to 8, and the output side
// sets the sustained rate. QueueDepth jobs can wait between the two sides. No
// clearing pass after reset. The capacity register may be written only while idle.
module lsb_first_bit_field_packer_top #(
  parameter int unsigned QueueDepth = lbfp_pkg::DefQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,    // capacity_bytes
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // [63:0] field_value, [70:64] field_width, pad
  input  wire logic        s_axis_tuser,  // [0] action
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [7:0] out_byte, [9:8] status,
                                          // [28:10] bits_written, pad
  output logic             m_axis_tuser,  // [0] byte_valid
  output logic             m_axis_tlast   // last
);

  lbfp_pkg::job_t              push_job;
  lbfp_pkg::job_t              head_job;
  logic                        q_full, q_empty, q_pop;
  logic                        in_accept;
  logic [7:0]                  res_byte;
  lbfp_pkg::status_e           res_status;
  logic [lbfp_pkg::PosW-1:0]   res_bits;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // front: state update and classification
  lbfp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .item_accept_i (in_accept),
    .item_action_i (s_axis_tuser),
    .item_value_i  (s_axis_tdata[63:0]),
    .item_width_i  (s_axis_tdata[70:64]),
    .job_o         (push_job)
  );

  // job queue
  lbfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .head_o     (head_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // back: byte emission
  lbfp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_job),
    .empty_i          (q_empty),
    .pop_o            (q_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_byte_o       (res_byte),
    .out_byte_valid_o (m_axis_tuser),
    .out_last_o       (m_axis_tlast),
    .out_status_o     (res_status),
    .out_bits_o       (res_bits)
  );

  // result packing
  assign m_axis_tdata = {3'b000, res_bits, res_status, res_byte};

endmodule

`default_nettype wire

>>> dv/lbfp_checker.sv
`timescale 1ns / 1ps

// watches the config, input and result channels, predicts the packed byte
// stream and compares every result transaction against it
module lbfp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [71:0] in_data_i,
  input  wire logic        in_user_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] out_data_i,
  input  wire logic        out_user_i,
  input  wire logic        out_last_i,
  output int               err_count_o,
  output int               pending_o,
  output logic [19:0]      bit_pos_o
);

  localparam int MaxReports = 10;

  typedef struct packed {
    logic [7:0]                out_byte;
    logic                      byte_valid;
    logic                      last;
    lbfp_pkg::status_e         status;
    logic [lbfp_pkg::PosW-1:0] bits;
  } byte_result_t;

  // shadow copy of the packer state
  logic [lbfp_pkg::CapW-1:0] cap_bytes;
  logic [7:0]                fill_byte;
  logic [19:0]               bit_pos;
  lbfp_pkg::status_e         stream_stat;

  byte_result_t packed_bytes_q[$];
  byte_result_t want;
  byte_result_t got;

  assign bit_pos_o = bit_pos;

  // apply one input transaction and queue the results it produces
  task automatic pack_input(input lbfp_pkg::action_e act, input logic [63:0] value,
                            input logic [6:0] width);
    logic [63:0]  bits_left;
    int unsigned  nbits;
    logic [7:0]   done_bytes[8];
    int           ndone;
    byte_result_t r;
    bits_left = '0;
    nbits     = 0;
    ndone     = 0;
    if (stream_stat == lbfp_pkg::StatusOk) begin
      if (act == lbfp_pkg::ActAlign) begin
        nbits = (bit_pos[2:0] != 3'd0) ? 8 - bit_pos[2:0] : 0;
      end else if (width > lbfp_pkg::MaxFieldBits) begin
        stream_stat = lbfp_pkg::StatusBadArg;
      end else begin
        nbits     = width;
        bits_left = value;
      end
      for (int i = 0; i < nbits; i++) begin
        // no room left for this bit: drop it and the rest of the field
        if ((bit_pos >> 3) >= cap_bytes) begin
          stream_stat = lbfp_pkg::StatusOverflow;
          break;
        end
        fill_byte[bit_pos[2:0]] = bits_left[0];
        bits_left = bits_left >> 1;
        bit_pos   = bit_pos + 20'd1;
        if (bit_pos[2:0] == 3'd0) begin
          done_bytes[ndone] = fill_byte;
          ndone++;
          fill_byte = '0;
        end
      end
    end
    if (ndone == 0) begin
      r = '{8'h00, 1'b0, 1'b1, stream_stat, bit_pos[lbfp_pkg::PosW-1:0]};
      packed_bytes_q.push_back(r);
    end else begin
      for (int k = 0; k < ndone; k++) begin
        r = '{done_bytes[k], 1'b1, (k == ndone - 1), stream_stat,
              bit_pos[lbfp_pkg::PosW-1:0]};
        packed_bytes_q.push_back(r);
      end
    end
  endtask

  // compare one result transaction with the oldest prediction
  task automatic check_result();
    got = '{out_data_i[7:0], out_user_i, out_last_i,
            lbfp_pkg::status_e'(out_data_i[9:8]), out_data_i[28:10]};
    if (packed_bytes_q.size() == 0) begin
      if (err_count_o < MaxReports)
        $display("unexpected result: byte=%h valid=%b last=%b status=%0d bits=%0d",
                 got.out_byte, got.byte_valid, got.last, got.status, got.bits);
      err_count_o++;
    end else begin
      want = packed_bytes_q.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.last !== want.last || got.status !== want.status ||
          got.bits !== want.bits) begin
        if (err_count_o < MaxReports) begin
          $display("mismatch: exp byte=%h valid=%b last=%b status=%0d bits=%0d",
                   want.out_byte, want.byte_valid, want.last, want.status, want.bits);
          $display("          got byte=%h valid=%b last=%b status=%0d bits=%0d",
                   got.out_byte, got.byte_valid, got.last, got.status, got.bits);
        end
        err_count_o++;
      end
    end
  endtask

  // predictions go in before the compare so a same-edge result still finds its entry
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_bytes   = lbfp_pkg::CapResetVal;
      fill_byte   = '0;
      bit_pos     = '0;
      stream_stat = lbfp_pkg::StatusOk;
      packed_bytes_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) cap_bytes = cfg_data_i;
      if (in_valid_i && in_ready_i)
        pack_input(lbfp_pkg::action_e'(in_user_i), in_data_i[63:0], in_data_i[70:64]);
      if (out_valid_i && out_ready_i) check_result();
      pending_o = packed_bytes_q.size();
    end
  end

endmodule

>>> dv/tb_lsb_first_bit_field_packer_top.sv
`timescale 1ns / 1ps

module tb_lsb_first_bit_field_packer_top;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // [63:0] field_value, [70:64] field_width, pad
  logic        s_axis_tuser = 1'b0; // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [7:0] out_byte, [9:8] status, [28:10] bits_written
  logic        m_axis_tuser;        // [0] byte_valid
  logic        m_axis_tlast;

  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  int          err_count;
  int          pending;
  logic [19:0] bit_pos;
  int          tx_idle_pct = 28;
  int          rx_idle_pct = 83;
  int          cycle_count = 0;

  lsb_first_bit_field_packer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lbfp_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .out_last_i  (m_axis_tlast),
    .err_count_o (err_count),
    .pending_o   (pending),
    .bit_pos_o   (bit_pos)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // handshakes as seen at the rising edge, read back at the falling edge
  always @(posedge clk_i) begin
    in_fire  <= s_axis_tvalid && s_axis_tready;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input lbfp_pkg::action_e act, input logic [63:0] value,
                           input logic [6:0] width);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, width, value};
    s_axis_tuser  <= act;
    do @(negedge clk_i); while (!in_fire);
  endtask

  // hold the sender off until every predicted result has drained
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // random well-formed fields, biased toward full and tiny widths
  task automatic send_random_items(input int count);
    lbfp_pkg::action_e act;
    logic [6:0]        width;
    int unsigned       pick;
    repeat (count) begin
      act  = ($urandom_range(0, 99) < 12) ? lbfp_pkg::ActAlign : lbfp_pkg::ActWrite;
      pick = $urandom_range(0, 9);
      if (pick < 2) width = 7'd64;
      else if (pick == 2) width = 7'd0;
      else if (pick < 6) width = 7'($urandom_range(1, 8));
      else width = 7'($urandom_range(1, 63));
      send_item(act, {$urandom, $urandom}, width);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase one: slow receiver
    write_capacity(16'hFFFF);
    send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd0);
    send_item(lbfp_pkg::ActAlign, {$urandom, $urandom}, 7'd0);
    send_item(lbfp_pkg::ActWrite, 64'h1, 7'd1);
    send_item(lbfp_pkg::ActWrite, '1, 7'd64);
    send_item(lbfp_pkg::ActAlign, '1, 7'd127);
    send_item(lbfp_pkg::ActWrite, '1, 7'd64);
    send_item(lbfp_pkg::ActWrite, '0, 7'd64);
    send_item(lbfp_pkg::ActWrite, 64'hA5C3_0F1E_8421_7BDE, 7'd64);
    send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd7);
    send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd1);
    send_item(lbfp_pkg::ActWrite, '1, 7'd5);
    send_item(lbfp_pkg::ActAlign, '0, 7'd0);
    send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd63);
    send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd62);
    send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd3);
    send_item(lbfp_pkg::ActAlign, {$urandom, $urandom}, 7'd64);
    send_item(lbfp_pkg::ActAlign, {$urandom, $urandom}, 7'd5);

    // full buffer: zero widths and aligned aligns must not overflow
    wait_idle();
    write_capacity(16'd0);
    send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd0);
    send_item(lbfp_pkg::ActAlign, {$urandom, $urandom}, 7'd0);
    send_item(lbfp_pkg::ActWrite, '1, 7'd0);
    wait_idle();
    write_capacity(16'(bit_pos >> 3));
    send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd0);
    send_item(lbfp_pkg::ActAlign, '1, 7'd9);
    wait_idle();
    write_capacity(16'($urandom_range(32'(bit_pos >> 3) + 3000, 65535)));
    send_random_items(90);

    // phase two: slow sender
    wait_idle();
    tx_idle_pct = 83;
    rx_idle_pct = 28;
    write_capacity(16'($urandom_range(32'(bit_pos >> 3) + 2000, 65534)));
    send_random_items(90);

    // phase three: full rate, run ends in a sticky error
    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    if ($urandom_range(0, 1) == 0) begin
      write_capacity(16'hFFFF);
      send_random_items(40);
      send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'($urandom_range(65, 127)));
      send_item(lbfp_pkg::ActWrite, '1, 7'd127);
      send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd65);
      send_random_items(15);
    end else begin
      write_capacity(16'(32'(bit_pos >> 3) + $urandom_range(1, 24)));
      send_random_items(50);
      send_item(lbfp_pkg::ActWrite, {$urandom, $urandom}, 7'd100);
      send_random_items(5);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
